[design/mwo_pkg.sv]
package mwo_pkg;

  // fixed field widths
  localparam int unsigned WHEELS          = 4;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned COUNT_EXT_W     = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned SCALE_W         = 32;
  localparam int unsigned ACC_W           = 48;
  localparam int unsigned TRAVEL_W        = 32;
  localparam int unsigned KIND_W          = 3;

  // stream packing
  localparam int unsigned IN_DATA_W  = WHEELS * FIELD_W;
  localparam int unsigned OUT_DATA_W = 3 * ACC_W + TRAVEL_W;
  localparam int unsigned OUT_USER_W = KIND_W + 1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE    = 1'd1;

  // motion codes
  localparam logic [KIND_W-1:0] KIND_FWD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CW    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CCW   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd6;

  // accumulator selection
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_HEAD = 2'd2;

  // sign patterns of the wheel deltas, wheel one in bit 0
  localparam logic [WHEELS-1:0] PAT_FWD   = 4'b0000;
  localparam logic [WHEELS-1:0] PAT_BACK  = 4'b1111;
  localparam logic [WHEELS-1:0] PAT_LEFT  = 4'b0110;
  localparam logic [WHEELS-1:0] PAT_RIGHT = 4'b1001;
  localparam logic [WHEELS-1:0] PAT_CW    = 4'b1010;
  localparam logic [WHEELS-1:0] PAT_CCW   = 4'b0101;

  typedef struct packed {
    logic              active;
    logic              neg;
    logic [1:0]        axis;
    logic [KIND_W-1:0] kind;
  } step_ctl_t;

  // map a sign pattern to a motion and its accumulator update
  function automatic step_ctl_t classify(input logic [WHEELS-1:0] neg_pat);
    step_ctl_t c;
    c.active = 1'b1;
    c.neg    = 1'b0;
    c.axis   = AXIS_X;
    c.kind   = KIND_NONE;
    case (neg_pat)
      PAT_FWD: begin
        c.kind = KIND_FWD;
      end
      PAT_BACK: begin
        c.kind = KIND_BACK;
        c.neg  = 1'b1;
      end
      PAT_LEFT: begin
        c.kind = KIND_LEFT;
        c.axis = AXIS_Y;
        c.neg  = 1'b1;
      end
      PAT_RIGHT: begin
        c.kind = KIND_RIGHT;
        c.axis = AXIS_Y;
      end
      PAT_CW: begin
        c.kind = KIND_CW;
        c.axis = AXIS_HEAD;
      end
      PAT_CCW: begin
        c.kind = KIND_CCW;
        c.axis = AXIS_HEAD;
        c.neg  = 1'b1;
      end
      default: begin
        c.active = 1'b0;
      end
    endcase
    return c;
  endfunction

endpackage

[design/mecanum_wheel_odometry.sv]
// Four-wheel mecanum odometry. Each input item carries the absolute counts of
// four wheel encoders; the block forms wrapped signed deltas against the
// previous counts, classifies the sign pattern as forward, backward, left,
// right, clockwise or anticlockwise, scales the mean pulse magnitude by the
// distance or angle register (24 fraction bits), adds or subtracts it with
// saturation into x, y or heading, and adds the unscaled mean to a saturating
// travel counter. One result item comes out for every input item, holding
// all accumulators after that item. One item per clock is taken unless the
// output stalls; items pass input, delta and class, product and accumulator
// registers, the scale multiplier in its own stage before the 48-bit add.
// Every stage holds its item under back-pressure and fills its own bubbles.
module mecanum_wheel_odometry #(
  parameter int unsigned COUNT_WIDTH = mwo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // wheel_one_count, wheel_two_count, wheel_three_count, wheel_four_count
  input  logic [mwo_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pos_x, pos_y, heading, travel_pulses
  output logic [mwo_pkg::OUT_DATA_W-1:0]     m_tdata,
  // motion_kind, saturated
  output logic [mwo_pkg::OUT_USER_W-1:0]     m_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [mwo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mwo_pkg::SCALE_W-1:0]        cfg_wdata
);
  import mwo_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;

  logic [SCALE_W-1:0]      distance_per_pulse;
  logic [SCALE_W-1:0]      angle_per_pulse;

  logic                    cls_valid;
  logic                    cls_ready;
  step_ctl_t               cls_ctl;
  logic [COUNT_WIDTH-1:0]  cls_avg;

  logic                    mul_valid;
  logic                    mul_ready;
  step_ctl_t               mul_ctl;
  logic [COUNT_WIDTH-1:0]  mul_avg;
  logic [PROD_W-1:0]       mul_prod;

  logic signed [ACC_W-1:0] pos_x;
  logic signed [ACC_W-1:0] pos_y;
  logic signed [ACC_W-1:0] heading;
  logic [TRAVEL_W-1:0]     travel_pulses;
  logic [KIND_W-1:0]       motion_kind;
  logic                    saturated;

  // scale registers
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_pulse <= '0;
      angle_per_pulse    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISTANCE: distance_per_pulse <= cfg_wdata;
        REG_ANGLE:    angle_per_pulse    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  mwo_delta #(.COUNT_WIDTH(COUNT_WIDTH)) u_delta (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_counts (s_tdata),
    .out_valid (cls_valid),
    .out_ready (cls_ready),
    .out_ctl   (cls_ctl),
    .out_avg   (cls_avg)
  );

  mwo_scale #(.COUNT_WIDTH(COUNT_WIDTH)) u_scale (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (cls_valid),
    .in_ready           (cls_ready),
    .in_ctl             (cls_ctl),
    .in_avg             (cls_avg),
    .distance_per_pulse (distance_per_pulse),
    .angle_per_pulse    (angle_per_pulse),
    .out_valid          (mul_valid),
    .out_ready          (mul_ready),
    .out_ctl            (mul_ctl),
    .out_avg            (mul_avg),
    .out_prod           (mul_prod)
  );

  mwo_accum #(.COUNT_WIDTH(COUNT_WIDTH)) u_accum (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (mul_valid),
    .in_ready      (mul_ready),
    .in_ctl        (mul_ctl),
    .in_avg        (mul_avg),
    .in_prod       (mul_prod),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .travel_pulses (travel_pulses),
    .motion_kind   (motion_kind),
    .saturated     (saturated)
  );

  // result packing
  assign m_tdata = {travel_pulses, heading, pos_y, pos_x};
  assign m_tuser = {saturated, motion_kind};

endmodule

[design/mwo_delta.sv]
module mwo_delta #(
  parameter int unsigned COUNT_WIDTH = mwo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mwo_pkg::IN_DATA_W-1:0]  in_counts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mwo_pkg::step_ctl_t             out_ctl,
  output logic [COUNT_WIDTH-1:0]         out_avg
);
  import mwo_pkg::*;

  localparam int unsigned SUM_W = COUNT_WIDTH + 2;

  logic                   cap_valid;
  logic                   cap_ready;
  logic                   advance;
  logic [FIELD_W-1:0]     cap_count [WHEELS];
  logic [COUNT_WIDTH-1:0] last_count [WHEELS];

  logic [COUNT_EXT_W-1:0] ext_count [WHEELS];
  logic [COUNT_WIDTH-1:0] now_count [WHEELS];
  logic [COUNT_WIDTH-1:0] diff [WHEELS];
  logic [COUNT_WIDTH-1:0] mag [WHEELS];
  logic [WHEELS-1:0]      neg_pat;
  logic [SUM_W-1:0]       mag_sum;

  assign cap_ready = !out_valid || out_ready;
  assign in_ready  = !cap_valid || cap_ready;
  assign advance   = cap_valid && cap_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (in_ready) begin
      cap_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      for (int w = 0; w < WHEELS; w++) begin
        cap_count[w] <= in_counts[w*FIELD_W +: FIELD_W];
      end
    end
  end

  // wrapped deltas, magnitudes and their sum
  always_comb begin
    mag_sum = '0;
    for (int w = 0; w < WHEELS; w++) begin
      ext_count[w] = {{(COUNT_EXT_W-FIELD_W){1'b0}}, cap_count[w]};
      now_count[w] = ext_count[w][COUNT_WIDTH-1:0];
      diff[w]      = now_count[w] - last_count[w];
      neg_pat[w]   = diff[w][COUNT_WIDTH-1];
      mag[w]       = neg_pat[w] ? (~diff[w] + 1'b1) : diff[w];
      mag_sum      = mag_sum + SUM_W'(mag[w]);
    end
  end

  // stored counts always follow the latest item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WHEELS; w++) begin
        last_count[w] <= '0;
      end
    end else if (advance) begin
      for (int w = 0; w < WHEELS; w++) begin
        last_count[w] <= now_count[w];
      end
    end
  end

  // classification register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cap_ready) begin
      out_valid <= cap_valid;
    end
    if (advance) begin
      out_ctl <= classify(neg_pat);
      out_avg <= mag_sum[SUM_W-1:2];
    end
  end

endmodule

[design/mwo_scale.sv]
module mwo_scale #(
  parameter int unsigned COUNT_WIDTH = mwo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  mwo_pkg::step_ctl_t                        in_ctl,
  input  logic [COUNT_WIDTH-1:0]                    in_avg,
  input  logic [mwo_pkg::SCALE_W-1:0]               distance_per_pulse,
  input  logic [mwo_pkg::SCALE_W-1:0]               angle_per_pulse,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output mwo_pkg::step_ctl_t                        out_ctl,
  output logic [COUNT_WIDTH-1:0]                    out_avg,
  output logic [COUNT_WIDTH+mwo_pkg::SCALE_W-1:0]   out_prod
);
  import mwo_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;

  logic               load;
  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0]  prod;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // rotation uses the angle scale, translation the distance scale
  always_comb begin
    scale = (in_ctl.axis == AXIS_HEAD) ? angle_per_pulse : distance_per_pulse;
    prod  = PROD_W'(in_avg) * PROD_W'(scale);
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (load) begin
      out_ctl  <= in_ctl;
      out_avg  <= in_avg;
      out_prod <= prod;
    end
  end

endmodule

[design/mwo_accum.sv]
module mwo_accum #(
  parameter int unsigned COUNT_WIDTH = mwo_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  mwo_pkg::step_ctl_t                        in_ctl,
  input  logic [COUNT_WIDTH-1:0]                    in_avg,
  input  logic [COUNT_WIDTH+mwo_pkg::SCALE_W-1:0]   in_prod,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [mwo_pkg::ACC_W-1:0]          pos_x,
  output logic signed [mwo_pkg::ACC_W-1:0]          pos_y,
  output logic signed [mwo_pkg::ACC_W-1:0]          heading,
  output logic [mwo_pkg::TRAVEL_W-1:0]              travel_pulses,
  output logic [mwo_pkg::KIND_W-1:0]                motion_kind,
  output logic                                      saturated
);
  import mwo_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;
  localparam int unsigned SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;
  localparam int unsigned TSUM_W =
    ((COUNT_WIDTH > TRAVEL_W) ? COUNT_WIDTH : TRAVEL_W) + 1;

  logic                     load;
  logic [ACC_W-1:0]         acc_sel;
  logic signed [SUM_W-1:0]  acc_ext;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  acc_sum;
  logic                     acc_ovf;
  logic [ACC_W-1:0]         acc_new;
  logic [TSUM_W-1:0]        travel_sum;
  logic                     travel_ovf;
  logic [TRAVEL_W-1:0]      travel_new;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // saturating add or subtract into the selected accumulator
  always_comb begin
    case (in_ctl.axis)
      AXIS_X:    acc_sel = pos_x;
      AXIS_Y:    acc_sel = pos_y;
      AXIS_HEAD: acc_sel = heading;
      default:   acc_sel = pos_x;
    endcase
    acc_ext  = {{(SUM_W-ACC_W){acc_sel[ACC_W-1]}}, acc_sel};
    prod_ext = {{(SUM_W-PROD_W){1'b0}}, in_prod};
    acc_sum  = in_ctl.neg ? (acc_ext - prod_ext) : (acc_ext + prod_ext);
    // out of range when the bits above the field differ from its sign
    acc_ovf  = (acc_sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b0}}) &&
               (acc_sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b1}});
    if (acc_ovf) begin
      acc_new = acc_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                 : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  // travel counter clips at its top
  always_comb begin
    travel_sum = TSUM_W'(travel_pulses) + TSUM_W'(in_avg);
    travel_ovf = (travel_sum[TSUM_W-1:TRAVEL_W] != '0);
    travel_new = travel_ovf ? {TRAVEL_W{1'b1}} : travel_sum[TRAVEL_W-1:0];
  end

  // accumulators, also the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      heading       <= '0;
      travel_pulses <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load && in_ctl.active) begin
        case (in_ctl.axis)
          AXIS_X:    pos_x   <= acc_new;
          AXIS_Y:    pos_y   <= acc_new;
          AXIS_HEAD: heading <= acc_new;
          default:   pos_x   <= acc_new;
        endcase
        travel_pulses <= travel_new;
      end
    end
    if (load) begin
      motion_kind <= in_ctl.kind;
      saturated   <= in_ctl.active && (acc_ovf || travel_ovf);
    end
  end

endmodule

[test/mecanum_wheel_odometry_test.sv]
module mecanum_wheel_odometry_test;
  import mwo_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_AT    = 120;
  localparam int PRESSURE_LEN   = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HALF_RANGE     = 32768;
  localparam int PRINT_CAP      = 40;
  localparam logic signed [63:0] ACC_HI = 64'sd140737488355327;
  localparam logic signed [63:0] ACC_LO = -64'sd140737488355328;
  localparam logic [TRAVEL_W-1:0] TRAVEL_HI = '1;

  // one result item as the block should report it
  typedef struct {
    logic [ACC_W-1:0]    x;
    logic [ACC_W-1:0]    y;
    logic [ACC_W-1:0]    heading;
    logic [TRAVEL_W-1:0] travel;
    logic [KIND_W-1:0]   kind;
    logic                clipped;
  } pose_t;

  logic                   clk;
  logic                   rst = 1'b1;
  // wheel_one_count, wheel_two_count, wheel_three_count, wheel_four_count
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // pos_x, pos_y, heading, travel_pulses
  logic [OUT_DATA_W-1:0]  m_tdata;
  // motion_kind, saturated
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0]     cfg_wdata = '0;

  // predicted odometry state
  logic [FIELD_W-1:0]   last_seen [WHEELS];
  logic signed [63:0]   x_acc;
  logic signed [63:0]   y_acc;
  logic signed [63:0]   head_acc;
  logic [TRAVEL_W-1:0]  travel_acc;
  logic [SCALE_W-1:0]   dist_scale;
  logic [SCALE_W-1:0]   angle_scale;

  // stimulus side
  logic [FIELD_W-1:0]   stim_counts [WHEELS];
  logic [IN_DATA_W-1:0] wheel_q [$];
  pose_t                pose_q [$];
  int                   send_idle_pct = 36;
  int                   recv_idle_pct = 52;
  int                   fault_count = 0;
  int                   results_seen = 0;
  int                   hold_left = 0;
  logic                 pressure_done = 1'b0;
  int                   quiet_cycles = 0;

  mecanum_wheel_odometry i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturating add or subtract into a 48-bit accumulator
  function automatic logic clip_add(inout logic signed [63:0] acc,
                                    input logic [63:0] amount, input logic sub);
    logic signed [63:0] sum;
    sum = sub ? acc - $signed(amount) : acc + $signed(amount);
    if (sum > ACC_HI) begin
      acc = ACC_HI;
      return 1'b1;
    end
    if (sum < ACC_LO) begin
      acc = ACC_LO;
      return 1'b1;
    end
    acc = sum;
    return 1'b0;
  endfunction

  // update the odometry for one accepted item and queue the pose it yields
  function automatic void advance_odometry(input logic [IN_DATA_W-1:0] item);
    logic [FIELD_W-1:0]  now;
    logic [FIELD_W-1:0]  diff;
    logic [WHEELS-1:0]   neg;
    logic [17:0]         mag_sum;
    logic [63:0]         mean;
    logic [63:0]         amount;
    logic [KIND_W-1:0]   kind;
    logic                clipped;
    logic [TRAVEL_W:0]   travel_next;
    pose_t               p;
    mag_sum = '0;
    clipped = 1'b0;
    for (int w = 0; w < WHEELS; w++) begin
      now = item[w*FIELD_W +: FIELD_W];
      diff = now - last_seen[w];
      // half range counts as a negative move
      neg[w] = diff[FIELD_W-1];
      mag_sum += neg[w] ? (18'h10000 - 18'(diff)) : 18'(diff);
      last_seen[w] = now;
    end
    case (neg)
      PAT_FWD:   kind = KIND_FWD;
      PAT_BACK:  kind = KIND_BACK;
      PAT_LEFT:  kind = KIND_LEFT;
      PAT_RIGHT: kind = KIND_RIGHT;
      PAT_CW:    kind = KIND_CW;
      PAT_CCW:   kind = KIND_CCW;
      default:   kind = KIND_NONE;
    endcase
    if (kind != KIND_NONE) begin
      mean = 64'(mag_sum >> 2);
      amount = mean * ((kind == KIND_CW || kind == KIND_CCW) ? angle_scale : dist_scale);
      case (kind)
        KIND_FWD:   clipped = clip_add(x_acc, amount, 1'b0);
        KIND_BACK:  clipped = clip_add(x_acc, amount, 1'b1);
        KIND_LEFT:  clipped = clip_add(y_acc, amount, 1'b1);
        KIND_RIGHT: clipped = clip_add(y_acc, amount, 1'b0);
        KIND_CW:    clipped = clip_add(head_acc, amount, 1'b0);
        default:    clipped = clip_add(head_acc, amount, 1'b1);
      endcase
      travel_next = {1'b0, travel_acc} + (TRAVEL_W+1)'(mean);
      if (travel_next > {1'b0, TRAVEL_HI}) begin
        travel_acc = TRAVEL_HI;
        clipped = 1'b1;
      end else begin
        travel_acc = travel_next[TRAVEL_W-1:0];
      end
    end
    p.x       = x_acc[ACC_W-1:0];
    p.y       = y_acc[ACC_W-1:0];
    p.heading = head_acc[ACC_W-1:0];
    p.travel  = travel_acc;
    p.kind    = kind;
    p.clipped = clipped;
    pose_q.push_back(p);
  endfunction

  function automatic void queue_counts(input logic [FIELD_W-1:0] c1, c2, c3, c4);
    stim_counts[0] = c1;
    stim_counts[1] = c2;
    stim_counts[2] = c3;
    stim_counts[3] = c4;
    wheel_q.push_back({c4, c3, c2, c1});
  endfunction

  // queue an item that moves each wheel by the given signed delta
  function automatic void queue_move(input int d1, d2, d3, d4);
    queue_counts(stim_counts[0] + 16'(d1), stim_counts[1] + 16'(d2),
                 stim_counts[2] + 16'(d3), stim_counts[3] + 16'(d4));
  endfunction

  // mostly clean motions with random sizes, some odd patterns and raw noise
  function automatic void queue_random_move();
    int                d [WHEELS];
    int                mag;
    logic [WHEELS-1:0] pat;
    if ($urandom_range(9) == 0) begin
      queue_counts(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      return;
    end
    case ($urandom_range(6))
      0: pat = PAT_FWD;
      1: pat = PAT_BACK;
      2: pat = PAT_LEFT;
      3: pat = PAT_RIGHT;
      4: pat = PAT_CW;
      5: pat = PAT_CCW;
      default: begin
        pat = 4'($urandom_range(15));
        while (pat inside {PAT_FWD, PAT_BACK, PAT_LEFT, PAT_RIGHT, PAT_CW, PAT_CCW})
          pat = 4'($urandom_range(15));
      end
    endcase
    for (int w = 0; w < WHEELS; w++) begin
      case ($urandom_range(3))
        0: mag = $urandom_range(64);
        1: mag = $urandom_range(16'h0FFF);
        2: mag = $urandom_range(HALF_RANGE - 1);
        default: mag = pat[w] ? HALF_RANGE : ($urandom_range(1) ? HALF_RANGE - 1 : 0);
      endcase
      if (pat[w]) d[w] = (mag == 0) ? -1 : -mag;
      else d[w] = mag;
    end
    queue_move(d[0], d[1], d[2], d[3]);
  endfunction

  function automatic void compare_field(input string label, input logic [63:0] want, got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= PRINT_CAP)
        $display("%0t: %s mismatch: expected %h actual %h", $time, label, want, got);
    end
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SCALE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DISTANCE: dist_scale = value;
      REG_ANGLE:    angle_scale = value;
      default: ;
    endcase
  endtask

  // wait until every queued item went in and every pose came out
  task automatic wait_drained();
    @(negedge clk);
    while (wheel_q.size() != 0 || s_tvalid || pose_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, recv_pct, moves);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (moves) queue_random_move();
    wait_drained();
  endtask

  // sequence of phases
  initial begin
    for (int w = 0; w < WHEELS; w++) begin
      stim_counts[w] = '0;
      last_seen[w] = '0;
    end
    x_acc = '0;
    y_acc = '0;
    head_acc = '0;
    travel_acc = '0;
    dist_scale = '0;
    angle_scale = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // unit distance scale, half-unit angle scale, one of each motion and the wrap corners
    write_reg(REG_DISTANCE, 32'h0100_0000);
    write_reg(REG_ANGLE, 32'h0080_0000);
    queue_move(0, 0, 0, 0);
    queue_move(1, 2, 3, 4);
    queue_move(-5, -5, -5, -5);
    queue_move(7, -9, -11, 13);
    queue_move(-20, 30, 40, -50);
    queue_move(100, -100, 100, -100);
    queue_move(-64, 64, -64, 64);
    queue_move(-3, 4, 4, 4);
    queue_move(3, -4, -4, -4);
    queue_move(HALF_RANGE, HALF_RANGE, HALF_RANGE, HALF_RANGE);
    queue_move(HALF_RANGE - 1, HALF_RANGE - 1, HALF_RANGE - 1, HALF_RANGE - 1);
    queue_move(HALF_RANGE - 1, -HALF_RANGE, -HALF_RANGE, HALF_RANGE - 1);
    queue_move(-HALF_RANGE, HALF_RANGE - 1, -HALF_RANGE, HALF_RANGE - 1);
    queue_counts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(36, 52, 450);

    // full scales push every accumulator into both limits
    write_reg(REG_DISTANCE, '1);
    write_reg(REG_ANGLE, '1);
    repeat (2) queue_move(HALF_RANGE - 1, HALF_RANGE - 1, HALF_RANGE - 1, HALF_RANGE - 1);
    repeat (3) queue_move(-HALF_RANGE, -HALF_RANGE, -HALF_RANGE, -HALF_RANGE);
    repeat (2) queue_move(-HALF_RANGE, HALF_RANGE - 1, HALF_RANGE - 1, -HALF_RANGE);
    repeat (3) queue_move(HALF_RANGE - 1, -HALF_RANGE, -HALF_RANGE, HALF_RANGE - 1);
    repeat (2) queue_move(HALF_RANGE - 1, -HALF_RANGE, HALF_RANGE - 1, -HALF_RANGE);
    repeat (3) queue_move(-HALF_RANGE, HALF_RANGE - 1, -HALF_RANGE, HALF_RANGE - 1);
    run_phase(36, 52, 400);

    // zero scales, idling swapped
    write_reg(REG_DISTANCE, '0);
    write_reg(REG_ANGLE, '0);
    run_phase(52, 36, 350);

    // random scales, no idling
    write_reg(REG_DISTANCE, $urandom);
    write_reg(REG_ANGLE, $urandom);
    run_phase(0, 0, 400);

    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // driver: offer queued items, predict each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) advance_odometry(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (wheel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= wheel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
      pressure_done <= 1'b1;
      hold_left <= PRESSURE_LEN;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each pose against the oldest prediction
  always @(posedge clk) begin : watch_results
    pose_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (pose_q.size() == 0) begin
        fault_count++;
        if (fault_count <= PRINT_CAP)
          $display("%0t: unexpected item: expected none actual %h %h",
                   $time, m_tdata, m_tuser);
      end else begin
        want = pose_q.pop_front();
        compare_field("pos_x", 64'(want.x), 64'(m_tdata[ACC_W-1:0]));
        compare_field("pos_y", 64'(want.y), 64'(m_tdata[2*ACC_W-1:ACC_W]));
        compare_field("heading", 64'(want.heading), 64'(m_tdata[3*ACC_W-1:2*ACC_W]));
        compare_field("travel_pulses", 64'(want.travel), 64'(m_tdata[OUT_DATA_W-1:3*ACC_W]));
        compare_field("motion_kind", 64'(want.kind), 64'(m_tuser[KIND_W-1:0]));
        compare_field("saturated", 64'(want.clipped), 64'(m_tuser[KIND_W]));
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
